// ----- rtl/core/lfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfs_pkg
// shared types, widths, register indexes and helpers for the flat shader
// ----------------------------------------------------------------------------
package lfs_pkg;

    // port field widths
    localparam int COORD_PORT_W = 32;
    localparam int COLOR_W      = 32;
    localparam int INT_W        = 16;
    localparam int LIGHT_W      = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // internal datapath widths
    localparam int NRM_EDGE_W = 31;                      // edges after range reduction
    localparam int PROD_W     = 2 * NRM_EDGE_W;          // edge products
    localparam int CROSS_W    = PROD_W + 1;              // cross product components
    localparam int NRM_W      = 32;                      // normalized normal components
    localparam int SQ_W       = 62;                      // squares and their sum
    localparam int DOT_W      = NRM_W + LIGHT_W;         // normal times light
    localparam int DSUM_W     = DOT_W + 2;               // sum of three dot terms
    localparam int NUM_W      = 47;                      // dot magnitude
    localparam int ROOT_W     = SQ_W / 2;                // normal length
    localparam int QUO_W      = 18;                      // quotient magnitude
    localparam int NORM_BITS  = 30;                      // target bit length

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z = 2'd2;

    typedef struct packed {
        logic               degen;
        logic               neg;
        logic [NUM_W-1:0]   num_mag;
        logic [COLOR_W-1:0] color;
    } t_sqrt_side;

    typedef struct packed {
        logic               degen;
        logic               neg;
        logic [COLOR_W-1:0] color;
    } t_div_side;

    // index of the highest set bit plus one, zero for zero
    function automatic logic [6:0] bit_len(input logic [63:0] m);
        logic [6:0] bl;
        bl = '0;
        for (int i = 0; i < 64; i++) begin
            if (m[i]) begin
                bl = 7'(i + 1);
            end
        end
        return bl;
    endfunction

endpackage

// ----- rtl/core/lfs_tri_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfs_tri_if
// triangle beat: three vertices and a base color
// ----------------------------------------------------------------------------
interface lfs_tri_if;
    logic                              valid;
    logic                              ready;
    logic [lfs_pkg::COORD_PORT_W-1:0]  v0_x;
    logic [lfs_pkg::COORD_PORT_W-1:0]  v0_y;
    logic [lfs_pkg::COORD_PORT_W-1:0]  v0_z;
    logic [lfs_pkg::COORD_PORT_W-1:0]  v1_x;
    logic [lfs_pkg::COORD_PORT_W-1:0]  v1_y;
    logic [lfs_pkg::COORD_PORT_W-1:0]  v1_z;
    logic [lfs_pkg::COORD_PORT_W-1:0]  v2_x;
    logic [lfs_pkg::COORD_PORT_W-1:0]  v2_y;
    logic [lfs_pkg::COORD_PORT_W-1:0]  v2_z;
    logic [lfs_pkg::COLOR_W-1:0]       base_color;

    modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, base_color, input ready);
    modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, base_color, output ready);
endinterface

// ----- rtl/core/lfs_shade_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfs_shade_if
// shading result beat
// ----------------------------------------------------------------------------
interface lfs_shade_if;
    logic                               valid;
    logic                               ready;
    logic signed [lfs_pkg::INT_W-1:0]   intensity;
    logic [lfs_pkg::COLOR_W-1:0]        shaded_color;
    logic                               degenerate;

    modport source (output valid, intensity, shaded_color, degenerate, input ready);
    modport sink   (input valid, intensity, shaded_color, degenerate, output ready);
endinterface

// ----- rtl/core/lfs_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfs_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module lfs_isqrt #(
    parameter int IN_W   = 62,
    parameter int SIDE_W = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [IN_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_vld,
    output logic [IN_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]   o_side
);
    localparam int N  = IN_W / 2;
    localparam int RW = IN_W + 1;

    logic [RW-1:0]     r_rem  [N];
    logic [RW-1:0]     r_res  [N];
    logic              r_vld  [N];
    logic [SIDE_W-1:0] r_side [N];

    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (N - 1 - j));
        logic [RW-1:0]     w_rem_in;
        logic [RW-1:0]     w_res_in;
        logic [RW-1:0]     w_trial;
        logic              w_vld_in;
        logic [SIDE_W-1:0] w_side_in;

        if (j == 0) begin : g_first
            assign w_rem_in  = RW'(i_rad);
            assign w_res_in  = '0;
            assign w_vld_in  = i_vld;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_res_in  = r_res[j-1];
            assign w_vld_in  = r_vld[j-1];
            assign w_side_in = r_side[j-1];
        end

        assign w_trial = w_res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem_in >= w_trial) begin
                    r_rem[j] <= w_rem_in - w_trial;
                    r_res[j] <= (w_res_in >> 1) + BIT;
                end else begin
                    r_rem[j] <= w_rem_in;
                    r_res[j] <= w_res_in >> 1;
                end
                r_side[j] <= w_side_in;
            end
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_root = r_res[N-1][N-1:0];
    assign o_side = r_side[N-1];

endmodule

// ----- rtl/core/lfs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfs_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module lfs_div #(
    parameter int NUM_W  = 47,
    parameter int DEN_W  = 31,
    parameter int Q_W    = 18,
    parameter int SIDE_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_vld,
    output logic [Q_W-1:0]     o_quo,
    output logic [SIDE_W-1:0]  o_side
);
    localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [RW-1:0]     r_rem  [Q_W];
    logic [DEN_W-1:0]  r_den  [Q_W];
    logic [Q_W-1:0]    r_quo  [Q_W];
    logic              r_vld  [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        localparam int K = Q_W - 1 - j;
        logic [RW-1:0]     w_rem_in;
        logic [DEN_W-1:0]  w_den_in;
        logic [Q_W-1:0]    w_quo_in;
        logic              w_vld_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [RW-1:0]     w_sub;

        if (j == 0) begin : g_first
            assign w_rem_in  = RW'(i_num);
            assign w_den_in  = i_den;
            assign w_quo_in  = '0;
            assign w_vld_in  = i_vld;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_den_in  = r_den[j-1];
            assign w_quo_in  = r_quo[j-1];
            assign w_vld_in  = r_vld[j-1];
            assign w_side_in = r_side[j-1];
        end

        assign w_sub = RW'(w_den_in) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem_in >= w_sub) begin
                    r_rem[j] <= w_rem_in - w_sub;
                    r_quo[j] <= w_quo_in | (Q_W'(1) << K);
                end else begin
                    r_rem[j] <= w_rem_in;
                    r_quo[j] <= w_quo_in;
                end
                r_den[j]  <= w_den_in;
                r_side[j] <= w_side_in;
            end
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_quo  = r_quo[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

// ----- rtl/core/lambert_flat_shade_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lambert_flat_shade_top
// flat lambertian shading of one triangle per beat
//
// i_tri carries one triangle (three Q16.16 vertices) and an RGBA base color;
// o_shade returns the Q1.14 intensity, the shaded color (alpha untouched)
// and a flag for a zero-length face normal. one result beat per input beat,
// in order.
// the light direction is set through i_cfg_we / i_cfg_idx / i_cfg_data
// (x, y, z at indexes 0, 1, 2) while the pipeline is empty.
// throughput: one triangle per cycle unless o_shade stalls. 58 register
// stages from input to result: 7 for edges, range reduction, products,
// cross product, normalization, squares with light products and sums, 31
// square root stages (one root bit each), 18 divider stages (one quotient
// bit each), a saturation stage and the color-scaling output register.
// the whole pipeline advances together; when o_shade is stalled holding a
// beat, i_tri.ready drops and every stage holds, so nothing is lost.
// reset clears all valid bits and loads the light direction with (0, 0, 1.0).
// ----------------------------------------------------------------------------
module lambert_flat_shade_top #(
    parameter int COORD_WIDTH      = 32,
    parameter int FACTOR_FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lfs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lfs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    lfs_tri_if.sink                           i_tri,
    lfs_shade_if.source                       o_shade
);
    localparam int EW  = COORD_WIDTH + 1;          // raw edge width
    localparam int NEW = lfs_pkg::NRM_EDGE_W;
    localparam int FW  = FACTOR_FRAC_BITS + 1;     // factor 0..1.0
    localparam int ONE = 1 << FACTOR_FRAC_BITS;
    localparam int LW  = lfs_pkg::LIGHT_W;
    localparam int CLW = lfs_pkg::COLOR_W;
    localparam int IW  = lfs_pkg::INT_W;
    localparam int QW  = lfs_pkg::QUO_W;

    // pipeline advance: whole pipe moves unless the output beat is stuck
    logic w_en;
    assign w_en        = !o_shade.valid || o_shade.ready;
    assign i_tri.ready = w_en;

    // light direction registers
    logic signed [LW-1:0] r_light_x;
    logic signed [LW-1:0] r_light_y;
    logic signed [LW-1:0] r_light_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x <= '0;
            r_light_y <= '0;
            r_light_z <= LW'(ONE);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lfs_pkg::REG_LIGHT_X: r_light_x <= i_cfg_data;
                lfs_pkg::REG_LIGHT_Y: r_light_y <= i_cfg_data;
                lfs_pkg::REG_LIGHT_Z: r_light_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: edges ab and ac ----------------
    logic [lfs_pkg::COORD_PORT_W-1:0] w_c [9];
    assign w_c[0] = i_tri.v0_x;
    assign w_c[1] = i_tri.v0_y;
    assign w_c[2] = i_tri.v0_z;
    assign w_c[3] = i_tri.v1_x;
    assign w_c[4] = i_tri.v1_y;
    assign w_c[5] = i_tri.v1_z;
    assign w_c[6] = i_tri.v2_x;
    assign w_c[7] = i_tri.v2_y;
    assign w_c[8] = i_tri.v2_z;

    logic signed [EW-1:0] n_e1 [6];
    logic signed [EW-1:0] r_e1 [6];
    logic [CLW-1:0]       r_col1;
    logic                 r_vld1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // only the low COORD_WIDTH bits count, sign-extended
            n_e1[i]   = $signed({w_c[3+i][COORD_WIDTH-1], w_c[3+i][COORD_WIDTH-1:0]})
                      - $signed({w_c[i][COORD_WIDTH-1], w_c[i][COORD_WIDTH-1:0]});
            n_e1[3+i] = $signed({w_c[6+i][COORD_WIDTH-1], w_c[6+i][COORD_WIDTH-1:0]})
                      - $signed({w_c[i][COORD_WIDTH-1], w_c[i][COORD_WIDTH-1:0]});
        end
    end

    // ---------------- stage 2: range reduce edges to 30 bits ----------------
    logic [EW-1:0]          w_e_or;
    logic [6:0]             w_e_bl;
    logic [6:0]             w_e_sh;
    logic signed [NEW-1:0]  n_e2 [6];
    logic signed [NEW-1:0]  r_e2 [6];
    logic [CLW-1:0]         r_col2;
    logic                   r_vld2;

    always_comb begin
        logic signed [63:0] wide;
        // OR of magnitudes has the same bit length as the largest magnitude
        w_e_or = '0;
        for (int i = 0; i < 6; i++) begin
            w_e_or = w_e_or | (r_e1[i] < 0 ? EW'(-r_e1[i]) : EW'(r_e1[i]));
        end
        w_e_bl = lfs_pkg::bit_len(64'(w_e_or));
        w_e_sh = (w_e_bl > 7'(lfs_pkg::NORM_BITS)) ? w_e_bl - 7'(lfs_pkg::NORM_BITS) : '0;
        for (int i = 0; i < 6; i++) begin
            wide    = 64'(r_e1[i]);
            n_e2[i] = NEW'(wide >>> w_e_sh);   // arithmetic shift floors
        end
    end

    // ---------------- stage 3: edge products ----------------
    logic signed [lfs_pkg::PROD_W-1:0] r_p [6];
    logic [CLW-1:0]                    r_col3;
    logic                              r_vld3;

    // ---------------- stage 4: cross product ----------------
    logic signed [lfs_pkg::CROSS_W-1:0] r_n4 [3];
    logic [CLW-1:0]                     r_col4;
    logic                               r_vld4;

    // ---------------- stage 5: normalize cross to 30 bits ----------------
    logic [lfs_pkg::CROSS_W-1:0]       w_n_or;
    logic [6:0]                        w_n_bl;
    logic signed [lfs_pkg::NRM_W-1:0]  n_n5 [3];
    logic signed [lfs_pkg::NRM_W-1:0]  r_n5 [3];
    logic                              r_degen5;
    logic [CLW-1:0]                    r_col5;
    logic                              r_vld5;

    always_comb begin
        logic signed [63:0] wide;
        w_n_or = '0;
        for (int i = 0; i < 3; i++) begin
            w_n_or = w_n_or | (r_n4[i] < 0 ? lfs_pkg::CROSS_W'(-r_n4[i])
                                           : lfs_pkg::CROSS_W'(r_n4[i]));
        end
        w_n_bl = lfs_pkg::bit_len(64'(w_n_or));
        for (int i = 0; i < 3; i++) begin
            wide = 64'(r_n4[i]);
            if (w_n_bl > 7'(lfs_pkg::NORM_BITS)) begin
                n_n5[i] = lfs_pkg::NRM_W'(wide >>> (w_n_bl - 7'(lfs_pkg::NORM_BITS)));
            end else begin
                n_n5[i] = lfs_pkg::NRM_W'(wide <<< (7'(lfs_pkg::NORM_BITS) - w_n_bl));
            end
        end
    end

    // ---------------- stage 6: squares and light products ----------------
    logic [lfs_pkg::SQ_W-1:0]          r_sq [3];
    logic signed [lfs_pkg::DOT_W-1:0]  r_d  [3];
    logic                              r_degen6;
    logic [CLW-1:0]                    r_col6;
    logic                              r_vld6;

    logic signed [63:0] w_sq_full [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sq_full[i] = r_n5[i] * r_n5[i];
        end
    end

    // ---------------- stage 7: sums ----------------
    logic signed [lfs_pkg::DSUM_W-1:0] w_dsum;
    logic [lfs_pkg::SQ_W-1:0]          r_sumsq;
    lfs_pkg::t_sqrt_side               n_side7;
    lfs_pkg::t_sqrt_side               r_side7;
    logic                              r_vld7;

    always_comb begin
        w_dsum = lfs_pkg::DSUM_W'(r_d[0]) + lfs_pkg::DSUM_W'(r_d[1])
               + lfs_pkg::DSUM_W'(r_d[2]);
        n_side7.degen   = r_degen6;
        n_side7.neg     = w_dsum > 0;      // numerator is the negated dot
        n_side7.num_mag = (w_dsum < 0) ? lfs_pkg::NUM_W'(-w_dsum)
                                       : lfs_pkg::NUM_W'(w_dsum);
        n_side7.color   = r_col6;
    end

    // control: valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
            r_vld7 <= 1'b0;
        end else if (w_en) begin
            r_vld1 <= i_tri.valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
            r_vld7 <= r_vld6;
        end
    end

    // datapath stages 1 to 7
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1   <= n_e1;
            r_col1 <= i_tri.base_color;

            r_e2   <= n_e2;
            r_col2 <= r_col1;

            r_p[0] <= r_e2[1] * r_e2[5];
            r_p[1] <= r_e2[2] * r_e2[4];
            r_p[2] <= r_e2[2] * r_e2[3];
            r_p[3] <= r_e2[0] * r_e2[5];
            r_p[4] <= r_e2[0] * r_e2[4];
            r_p[5] <= r_e2[1] * r_e2[3];
            r_col3 <= r_col2;

            for (int i = 0; i < 3; i++) begin
                r_n4[i] <= lfs_pkg::CROSS_W'(r_p[2*i]) - lfs_pkg::CROSS_W'(r_p[2*i+1]);
            end
            r_col4 <= r_col3;

            r_n5     <= n_n5;
            r_degen5 <= (w_n_or == '0);
            r_col5   <= r_col4;

            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= w_sq_full[i][lfs_pkg::SQ_W-1:0];
            end
            r_d[0]   <= r_n5[0] * r_light_x;
            r_d[1]   <= r_n5[1] * r_light_y;
            r_d[2]   <= r_n5[2] * r_light_z;
            r_degen6 <= r_degen5;
            r_col6   <= r_col5;

            r_sumsq <= r_sq[0] + r_sq[1] + r_sq[2];
            r_side7 <= n_side7;
        end
    end

    // ---------------- normal length ----------------
    logic                                 w_sqrt_vld;
    logic [lfs_pkg::ROOT_W-1:0]           w_len;
    logic [$bits(lfs_pkg::t_sqrt_side)-1:0] w_sqrt_side_raw;
    lfs_pkg::t_sqrt_side                  w_sqrt_side;

    lfs_isqrt #(
        .IN_W   (lfs_pkg::SQ_W),
        .SIDE_W ($bits(lfs_pkg::t_sqrt_side))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld7),
        .i_rad   (r_sumsq),
        .i_side  (r_side7),
        .o_vld   (w_sqrt_vld),
        .o_root  (w_len),
        .o_side  (w_sqrt_side_raw)
    );
    assign w_sqrt_side = w_sqrt_side_raw;

    // ---------------- dot over length ----------------
    lfs_pkg::t_div_side                   w_div_side_in;
    logic [$bits(lfs_pkg::t_div_side)-1:0] w_div_side_raw;
    lfs_pkg::t_div_side                   w_div_side;
    logic                                 w_div_vld;
    logic [QW-1:0]                        w_quo;

    assign w_div_side_in.degen = w_sqrt_side.degen;
    assign w_div_side_in.neg   = w_sqrt_side.neg;
    assign w_div_side_in.color = w_sqrt_side.color;

    lfs_div #(
        .NUM_W  (lfs_pkg::NUM_W),
        .DEN_W  (lfs_pkg::ROOT_W),
        .Q_W    (QW),
        .SIDE_W ($bits(lfs_pkg::t_div_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sqrt_vld),
        .i_num   (w_sqrt_side.num_mag),
        .i_den   (w_len),
        .i_side  (w_div_side_in),
        .o_vld   (w_div_vld),
        .o_quo   (w_quo),
        .o_side  (w_div_side_raw)
    );
    assign w_div_side = w_div_side_raw;

    // ---------------- saturate and clamp ----------------
    logic signed [QW+1:0]  w_qs;
    logic signed [IW-1:0]  n_int;
    logic [FW-1:0]         n_factor;
    logic signed [IW-1:0]  r_int_a;
    logic [FW-1:0]         r_factor_a;
    logic                  r_degen_a;
    logic [CLW-1:0]        r_col_a;
    logic                  r_vld_a;

    always_comb begin
        w_qs = w_div_side.neg ? -(QW+2)'(w_quo) : (QW+2)'(w_quo);
        if (w_div_side.degen) begin
            n_int = '0;
        end else if (w_qs > (QW+2)'(32767)) begin
            n_int = 16'sh7FFF;
        end else if (w_qs < -(QW+2)'(32768)) begin
            n_int = 16'sh8000;
        end else begin
            n_int = IW'(w_qs);
        end
        if (n_int < 0) begin
            n_factor = '0;
        end else if (int'(n_int) > ONE) begin
            n_factor = FW'(ONE);
        end else begin
            n_factor = FW'(n_int);
        end
    end

    // ---------------- color scaling, output register ----------------
    logic [8+FW-1:0] w_pr_r;
    logic [8+FW-1:0] w_pr_g;
    logic [8+FW-1:0] w_pr_b;
    logic            r_vld_out;
    logic signed [IW-1:0] r_int_out;
    logic [CLW-1:0]  r_col_out;
    logic            r_degen_out;

    assign w_pr_r = r_col_a[31:24] * r_factor_a;
    assign w_pr_g = r_col_a[23:16] * r_factor_a;
    assign w_pr_b = r_col_a[15:8]  * r_factor_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a   <= 1'b0;
            r_vld_out <= 1'b0;
        end else if (w_en) begin
            r_vld_a   <= w_div_vld;
            r_vld_out <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_int_a    <= n_int;
            r_factor_a <= n_factor;
            r_degen_a  <= w_div_side.degen;
            r_col_a    <= w_div_side.color;

            r_int_out   <= r_int_a;
            r_degen_out <= r_degen_a;
            r_col_out   <= {w_pr_r[FACTOR_FRAC_BITS +: 8], w_pr_g[FACTOR_FRAC_BITS +: 8],
                            w_pr_b[FACTOR_FRAC_BITS +: 8], r_col_a[7:0]};
        end
    end

    assign o_shade.valid        = r_vld_out;
    assign o_shade.intensity    = r_int_out;
    assign o_shade.shaded_color = r_col_out;
    assign o_shade.degenerate   = r_degen_out;

endmodule

// ----- rtl/core/lfs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfs_checker
// port-level checks on the flat shader, bound to the top level
// ----------------------------------------------------------------------------
module lfs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [lfs_pkg::INT_W-1:0]  i_intensity,
    input logic [lfs_pkg::COLOR_W-1:0]       i_shaded_color,
    input logic                              i_degenerate
);
    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_shaded_color)
            && $stable(i_intensity) && $stable(i_degenerate))
        else $error("result beat changed while stalled");

    // input is taken whenever the output slot frees up
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output slot");

    // a degenerate face is black with zero intensity
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degenerate |-> i_intensity == 0 && i_shaded_color[31:8] == 0)
        else $error("degenerate beat not black");

    // non-positive intensity clamps the factor to zero
    a_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_intensity <= 0 |-> i_shaded_color[31:8] == 0)
        else $error("unlit face has color");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");
endmodule

bind lambert_flat_shade_top lfs_checker u_lfs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_tri.ready),
    .i_out_valid    (o_shade.valid),
    .i_out_ready    (o_shade.ready),
    .i_intensity    (o_shade.intensity),
    .i_shaded_color (o_shade.shaded_color),
    .i_degenerate   (o_shade.degenerate)
);

// ----- sim/tb_lambert_flat_shade_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lambert_flat_shade_top
// self-checking bench for the flat lambertian shader
//
// triangles go in on the tri channel and shading beats are checked against
// an in-bench fixed-point model of the shader: edges, cross product, normal
// rescale, integer root, dot product with the light, saturation and color
// scaling. the light direction is reprogrammed between phases while the
// pipeline is empty. both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_lambert_flat_shade_top;

    localparam int  FRAC      = 14;
    localparam int  LAT       = 58;
    localparam int  N_PHASE   = 5;
    localparam int  PHASE_N   = 400;
    localparam longint LIMIT  = 400000;

    typedef struct {
        logic [31:0] v [9];
        logic [31:0] color;
    } t_triangle;

    typedef struct {
        logic signed [15:0] intensity;
        logic [31:0]        color;
        logic               degen;
    } t_shade;

    // ------------------------------------------------------------------------
    // shading model and expected-beat store
    // ------------------------------------------------------------------------
    class t_shade_scoreboard;
        longint light [3];
        t_shade pending [$];
        int     errors;

        function new();
            light[0] = 0;
            light[1] = 0;
            light[2] = longint'(1) << FRAC;
            errors   = 0;
        endfunction

        static function int bit_length(longint unsigned m);
            int n;
            n = 0;
            while (m != 0) begin
                m = m >> 1;
                n++;
            end
            return n;
        endfunction

        static function longint unsigned int_root(longint unsigned v);
            longint unsigned res, bit_w;
            res   = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > v) bit_w = bit_w >> 2;
            while (bit_w != 0) begin
                if (v >= res + bit_w) begin
                    v   = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
            return res;
        endfunction

        static function longint unsigned magnitude(longint x);
            return (x < 0) ? -x : x;
        endfunction

        function t_shade shade(t_triangle t);
            longint v [9];
            longint e [6];
            longint n [3];
            longint unsigned maxm, sumsq, len;
            longint num, q, fac;
            longint unsigned r, g, b;
            int bl;
            t_shade s;
            for (int i = 0; i < 9; i++) v[i] = longint'($signed(t.v[i]));
            for (int i = 0; i < 3; i++) begin
                e[i]     = v[3+i] - v[i];
                e[3+i]   = v[6+i] - v[i];
            end
            maxm = 0;
            for (int i = 0; i < 6; i++) if (magnitude(e[i]) > maxm) maxm = magnitude(e[i]);
            bl = bit_length(maxm);
            // floor division keeps the edge products inside 62 bits
            if (bl > 30) for (int i = 0; i < 6; i++) e[i] = e[i] >>> (bl - 30);
            n[0] = e[1] * e[5] - e[2] * e[4];
            n[1] = e[2] * e[3] - e[0] * e[5];
            n[2] = e[0] * e[4] - e[1] * e[3];
            maxm = 0;
            for (int i = 0; i < 3; i++) if (magnitude(n[i]) > maxm) maxm = magnitude(n[i]);
            s.degen     = (maxm == 0);
            s.intensity = '0;
            q = 0;
            if (maxm != 0) begin
                bl = bit_length(maxm);
                for (int i = 0; i < 3; i++) begin
                    if (bl > 30) n[i] = n[i] >>> (bl - 30);
                    else if (bl < 30) n[i] = n[i] <<< (30 - bl);
                end
                sumsq = 0;
                for (int i = 0; i < 3; i++) sumsq += longint'(n[i] * n[i]);
                len = int_root(sumsq);
                num = -(n[0] * light[0] + n[1] * light[1] + n[2] * light[2]);
                q   = num / longint'(len);
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
                s.intensity = q[15:0];
            end
            fac = q;
            if (fac < 0) fac = 0;
            if (fac > (longint'(1) << FRAC)) fac = longint'(1) << FRAC;
            r = (longint'(t.color[31:24]) * fac) >> FRAC;
            g = (longint'(t.color[23:16]) * fac) >> FRAC;
            b = (longint'(t.color[15:8]) * fac) >> FRAC;
            s.color = {r[7:0], g[7:0], b[7:0], t.color[7:0]};
            return s;
        endfunction

        function void note_triangle(t_triangle t);
            pending.push_back(shade(t));
        endfunction

        function void check_shade(t_shade got);
            t_shade want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected shade beat: int %0d color %h degen %b",
                             got.intensity, got.color, got.degen);
                return;
            end
            want = pending.pop_front();
            if (got.intensity !== want.intensity || got.color !== want.color ||
                got.degen !== want.degen) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp int %0d col %h dg %b, got int %0d col %h dg %b",
                             want.intensity, want.color, want.degen,
                             got.intensity, got.color, got.degen);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    longint      cycles;
    bit          calm;      // no-idle stretch for both channels

    lfs_tri_if   tri_ch ();
    lfs_shade_if shade_ch ();

    t_shade_scoreboard sb;

    lambert_flat_shade_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tri      (tri_ch),
        .o_shade    (shade_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: even a fully stalled run stays far below this
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: check on each accepted beat, then pick the next ready
    always @(posedge i_clk) begin
        t_shade got;
        if (i_rst_n && shade_ch.valid && shade_ch.ready) begin
            got.intensity = shade_ch.intensity;
            got.color     = shade_ch.shaded_color;
            got.degen     = shade_ch.degenerate;
            sb.check_shade(got);
        end
        shade_ch.ready <= calm || ($urandom_range(99) >= 26);
    end

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 26);
    endfunction

    // one light register write per cycle, the enable stays high across them
    task automatic set_light(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= 2'd3;           // unmapped index, must be ignored
        i_cfg_data <= 16'($urandom());
        @(posedge i_clk);
        i_cfg_idx  <= lfs_pkg::REG_LIGHT_X;
        i_cfg_data <= x;
        @(posedge i_clk);
        i_cfg_idx  <= lfs_pkg::REG_LIGHT_Y;
        i_cfg_data <= y;
        @(posedge i_clk);
        i_cfg_idx  <= lfs_pkg::REG_LIGHT_Z;
        i_cfg_data <= z;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.light[0] = longint'($signed(x));
        sb.light[1] = longint'($signed(y));
        sb.light[2] = longint'($signed(z));
    endtask

    // drive one triangle beat; valid stays high into the next beat when no gap
    task automatic send_triangle(t_triangle t);
        while (idle_now()) begin
            tri_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tri_ch.valid      <= 1'b1;
        tri_ch.v0_x       <= t.v[0];
        tri_ch.v0_y       <= t.v[1];
        tri_ch.v0_z       <= t.v[2];
        tri_ch.v1_x       <= t.v[3];
        tri_ch.v1_y       <= t.v[4];
        tri_ch.v1_z       <= t.v[5];
        tri_ch.v2_x       <= t.v[6];
        tri_ch.v2_y       <= t.v[7];
        tri_ch.v2_z       <= t.v[8];
        tri_ch.base_color <= t.color;
        do @(posedge i_clk); while (!tri_ch.ready);
        sb.note_triangle(t);
    endtask

    task automatic drain();
        tri_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    // vertex coordinate: mostly small scenes, some full range, some extremes
    function automatic logic [31:0] pick_coord(int kind);
        case (kind)
            0: return 32'($signed($urandom_range(32'h0003_ffff)) - 32'sh0002_0000);
            1: return $urandom();
            default: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
        endcase
    endfunction

    function automatic t_triangle random_triangle();
        t_triangle t;
        int kind, shape;
        kind  = ($urandom_range(99) < 70) ? 0 : (($urandom_range(99) < 80) ? 1 : 2);
        shape = $urandom_range(99);
        for (int i = 0; i < 9; i++) t.v[i] = pick_coord(kind);
        if (shape < 4) begin
            // repeated vertex: zero normal
            for (int i = 0; i < 3; i++) t.v[3+i] = t.v[i];
        end else if (shape < 7) begin
            // collinear: third vertex lies twice the first edge from the first vertex
            for (int i = 0; i < 3; i++) begin
                t.v[i]   = pick_coord(0);
                t.v[3+i] = pick_coord(0);
                t.v[6+i] = 2 * t.v[3+i] - t.v[i];
            end
        end
        t.color = $urandom();
        return t;
    endfunction

    function automatic t_triangle make_tri(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                                           logic [31:0] b0, logic [31:0] b1, logic [31:0] b2,
                                           logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                                           logic [31:0] col);
        t_triangle t;
        t.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
        t.color = col;
        return t;
    endfunction

    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MN  = 32'h8000_0000;
    localparam logic [31:0] MX  = 32'h7fff_ffff;

    initial begin
        logic [15:0] lx [N_PHASE];
        logic [15:0] ly [N_PHASE];
        logic [15:0] lz [N_PHASE];
        sb = new();
        cycles              = 0;
        calm                = 1'b0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        tri_ch.valid        = 1'b0;
        tri_ch.v0_x         = '0;
        tri_ch.v0_y         = '0;
        tri_ch.v0_z         = '0;
        tri_ch.v1_x         = '0;
        tri_ch.v1_y         = '0;
        tri_ch.v1_z         = '0;
        tri_ch.v2_x         = '0;
        tri_ch.v2_y         = '0;
        tri_ch.v2_z         = '0;
        tri_ch.base_color   = '0;
        shade_ch.ready      = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, with the reset light (0, 0, 1.0)
        // ccw triangle in xy: normal +z, light +z -> intensity -1.0
        send_triangle(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 32'hffff_ffff));
        // cw triangle: normal -z, intensity exactly one, color kept
        send_triangle(make_tri(0, 0, 0, 0, ONE, 0, ONE, 0, 0, 32'hffff_ffff));
        send_triangle(make_tri(0, 0, 0, 0, ONE, 0, ONE, 0, 0, 32'h8040_2011));
        // zero normal: repeated vertices and collinear ones
        send_triangle(make_tri(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 32'hffff_ffaa));
        send_triangle(make_tri(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 32'h1234_5678));
        // coordinate extremes: edges need range reduction
        send_triangle(make_tri(MN, MN, MN, MX, MN, MN, MN, MX, MN, 32'h0000_0000));
        send_triangle(make_tri(MX, MX, MX, MN, MX, MX, MX, MN, MX, 32'hffff_ffff));
        send_triangle(make_tri(MN, MX, 0, MX, MN, 0, MN, MN, MX, 32'hff00_ff00));
        // tiny triangle: normal shifted up
        send_triangle(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0, 32'h00ff_00ff));
        // oblique faces
        send_triangle(make_tri(0, 0, 0, 0, ONE, ONE, ONE, 0, 0, 32'hc0c0_c0c0));
        send_triangle(make_tri(0, 0, 0, ONE, 0, ONE, 0, ONE, 0, 32'h7f7f_7f7f));
        drain();

        // phase settings: flipped z light, extremes, zero light, random
        lx[0] = 16'h0000; ly[0] = 16'h0000; lz[0] = 16'hc000;
        lx[1] = 16'h8000; ly[1] = 16'h8000; lz[1] = 16'h8000;
        lx[2] = 16'h7fff; ly[2] = 16'h7fff; lz[2] = 16'h7fff;
        lx[3] = 16'h0000; ly[3] = 16'h0000; lz[3] = 16'h0000;
        lx[4] = 16'($urandom()); ly[4] = 16'($urandom()); lz[4] = 16'($urandom());

        for (int p = 0; p < N_PHASE; p++) begin
            set_light(lx[p], ly[p], lz[p]);
            if (p == 3) begin
                // zero light: a non-degenerate face shades to black without a flag
                send_triangle(make_tri(0, 0, 0, 0, ONE, 0, ONE, 0, 0, 32'hffff_ffff));
            end
            for (int k = 0; k < PHASE_N; k++) begin
                calm = (p == 1 && k >= 100 && k < 250);
                if (p == 2 && k == 200) begin
                    // hold off until the pipeline has emptied
                    tri_ch.valid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
                send_triangle(random_triangle());
            end
            calm = 1'b0;
            drain();
        end

        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
